// ===== sv/fsas_pkg.sv =====
// ----------------------------------------------------------------------------
// fsas_pkg: shared constants, types and microcode for the flame sensor scanner
// Holds field widths, register codes, the reciprocal table for the average
// and the control store of the sequencer.
// ----------------------------------------------------------------------------
package fsas_pkg;

  localparam int MAX_SENSORS = 5;

  localparam int SAMPLE_W   = 10;
  localparam int SENSOR_W   = 3;
  localparam int COUNT_CFG_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam int IDX_W   = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int CNT_W   = $clog2(MAX_SENSORS + 1);
  localparam int SUM_W   = SAMPLE_W + IDX_W;
  // divisor is below 8, so three extra bits make the reciprocal exact
  localparam int DIV_SH  = SUM_W + 3;
  localparam int RECIP_W = DIV_SH + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int QUOT_W  = PROD_W - DIV_SH;
  localparam int CMP_W   = SUM_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUN_LEVEL    = 2'd2;

  localparam logic [COUNT_CFG_W-1:0] RST_SENSOR_COUNT = 3'd1;
  localparam logic [SAMPLE_W-1:0]    RST_SENSITIVITY  = 10'd100;
  localparam logic [SAMPLE_W-1:0]    RST_SUN_LEVEL    = 10'd1023;

  // ceil(2^DIV_SH / d) for each possible divisor
  localparam int R1 = ((1 << DIV_SH) + 0) / 1;
  localparam int R2 = ((1 << DIV_SH) + 1) / 2;
  localparam int R3 = ((1 << DIV_SH) + 2) / 3;
  localparam int R4 = ((1 << DIV_SH) + 3) / 4;
  localparam int R5 = ((1 << DIV_SH) + 4) / 5;
  localparam int R6 = ((1 << DIV_SH) + 5) / 6;
  localparam int R7 = ((1 << DIV_SH) + 6) / 7;

  function automatic logic [RECIP_W-1:0] recip(input logic [2:0] d);
    logic [RECIP_W-1:0] r;
    r = '0;
    unique case (d)
      3'd1:    r = RECIP_W'(R1);
      3'd2:    r = RECIP_W'(R2);
      3'd3:    r = RECIP_W'(R3);
      3'd4:    r = RECIP_W'(R4);
      3'd5:    r = RECIP_W'(R5);
      3'd6:    r = RECIP_W'(R6);
      3'd7:    r = RECIP_W'(R7);
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef logic [2:0] step_t;

  localparam step_t ST_WAIT  = 3'd0;
  localparam step_t ST_FIRST = 3'd1;
  localparam step_t ST_LOOP  = 3'd2;
  localparam step_t ST_MUL   = 3'd3;
  localparam step_t ST_EMIT  = 3'd4;

  typedef enum logic [2:0] {
    C_NONE,
    C_NOACC,
    C_SUN,
    C_MORE,
    C_BUSY
  } cond_t;

  typedef struct packed {
    logic in_rdy;
    logic store;
    logic acc;
    logic mul;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic sun;
    logic more;
    logic busy;
  } flags_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_t cond;
    step_t jmp;
    step_t nxt;
  } uword_t;

  function automatic uword_t ucode_rom(input step_t s);
    uword_t w;
    w = '0;
    unique case (s)
      ST_WAIT: begin
        w.ctrl.in_rdy = 1'b1;
        w.cond        = C_NOACC;
        w.jmp         = ST_WAIT;
        w.nxt         = ST_FIRST;
      end
      ST_FIRST: begin
        w.ctrl.store = 1'b1;
        w.ctrl.acc   = 1'b1;
        w.cond       = C_SUN;
        w.jmp        = ST_EMIT;
        w.nxt        = ST_LOOP;
      end
      ST_LOOP: begin
        w.ctrl.acc = 1'b1;
        w.cond     = C_MORE;
        w.jmp      = ST_LOOP;
        w.nxt      = ST_MUL;
      end
      ST_MUL: begin
        w.ctrl.mul = 1'b1;
        w.cond     = C_NONE;
        w.jmp      = ST_MUL;
        w.nxt      = ST_EMIT;
      end
      ST_EMIT: begin
        w.ctrl.emit = 1'b1;
        w.cond      = C_BUSY;
        w.jmp       = ST_EMIT;
        w.nxt       = ST_WAIT;
      end
      default: begin
        w.cond = C_NONE;
        w.nxt  = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== sv/fsas_ifs.sv =====
// ----------------------------------------------------------------------------
// fsas_ifs: sample and result channels
// Valid/ready channels carrying one sample word and one result word.
// ----------------------------------------------------------------------------
interface fsas_sample_if;
  logic                          valid;
  logic                          ready;
  logic [fsas_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface fsas_result_if;
  logic                          valid;
  logic                          ready;
  logic [fsas_pkg::SENSOR_W-1:0] sensor_index;
  logic                          sun_suspected;
  logic                          flame_seen;

  modport source (output valid, output sensor_index, output sun_suspected,
                  output flame_seen, input ready);
  modport sink   (input valid, input sensor_index, input sun_suspected,
                  input flame_seen, output ready);
endinterface

// ===== sv/fsas_ucode.sv =====
// ----------------------------------------------------------------------------
// fsas_ucode: microcode sequencer
// Step counter over the control store with conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module fsas_ucode (
  input  logic             clk,
  input  logic             rst,
  input  fsas_pkg::flags_t flags,
  output fsas_pkg::ctrl_t  ctrl
);

  fsas_pkg::step_t  step;
  fsas_pkg::step_t  step_next;
  fsas_pkg::uword_t word;
  logic             hit;

  assign word = fsas_pkg::ucode_rom(step);
  assign ctrl = word.ctrl;

  always_comb begin
    unique case (word.cond)
      fsas_pkg::C_NONE:  hit = 1'b0;
      fsas_pkg::C_NOACC: hit = !flags.accept;
      fsas_pkg::C_SUN:   hit = flags.sun;
      fsas_pkg::C_MORE:  hit = flags.more;
      fsas_pkg::C_BUSY:  hit = flags.busy;
      default:           hit = 1'b0;
    endcase
    step_next = hit ? word.jmp : word.nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= fsas_pkg::ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= fsas_pkg::ST_EMIT)
    else $error("sequencer left its program");

  a_emit_returns: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit && !flags.busy) |=> step == fsas_pkg::ST_WAIT)
    else $error("sequencer did not return after result load");

  a_sun_skips: assert property (@(posedge clk) disable iff (rst)
    (step == fsas_pkg::ST_FIRST && flags.sun) |=> step == fsas_pkg::ST_EMIT)
    else $error("sunlight word did not skip averaging");

endmodule

// ===== sv/fsas_datapath.sv =====
// ----------------------------------------------------------------------------
// fsas_datapath: reading store, accumulator, average and result register
// Driven one control word per cycle by the sequencer.
// ----------------------------------------------------------------------------
module fsas_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  fsas_pkg::ctrl_t                   ctrl,
  output fsas_pkg::flags_t                  flags,
  input  logic                              sample_valid,
  input  logic [fsas_pkg::SAMPLE_W-1:0]     sample,
  input  logic [fsas_pkg::CNT_W-1:0]        n_active,
  input  logic [fsas_pkg::SAMPLE_W-1:0]     sensitivity,
  input  logic [fsas_pkg::SAMPLE_W-1:0]     sun_level,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [fsas_pkg::SENSOR_W-1:0]     sensor_index,
  output logic                              sun_suspected,
  output logic                              flame_seen
);

  logic [fsas_pkg::SAMPLE_W-1:0] readings [fsas_pkg::MAX_SENSORS];
  logic [fsas_pkg::SAMPLE_W-1:0] sample_r;
  logic [fsas_pkg::IDX_W-1:0]    idx_r;
  logic [fsas_pkg::IDX_W-1:0]    cur;
  logic [fsas_pkg::CNT_W-1:0]    n_r;
  logic [fsas_pkg::CNT_W-1:0]    i_cnt;
  logic [fsas_pkg::SUM_W-1:0]    sum;
  logic [fsas_pkg::PROD_W-1:0]   prod;

  logic                          accept;
  logic                          sun;
  logic                          busy;
  logic                          load;
  logic                          take;
  logic                          flame;
  logic [fsas_pkg::IDX_W-1:0]    start_idx;
  logic [fsas_pkg::CNT_W-1:0]    idx_inc;
  logic [fsas_pkg::QUOT_W-1:0]   quot;
  logic [fsas_pkg::CMP_W-1:0]    thresh;

  assign accept = sample_valid && ctrl.in_rdy;
  assign sun    = sample_r >= sun_level;
  assign busy   = out_valid && !out_ready;
  assign load   = ctrl.emit && !busy;

  assign flags.accept = accept;
  assign flags.sun    = sun;
  assign flags.more   = i_cnt < fsas_pkg::CNT_W'(fsas_pkg::MAX_SENSORS - 1);
  assign flags.busy   = busy;

  // selection restarts at zero if the count was lowered under it
  assign start_idx = (fsas_pkg::CNT_W'(cur) < n_active) ? cur : '0;
  assign take      = (i_cnt < n_r) && (fsas_pkg::CNT_W'(idx_r) != i_cnt);
  assign idx_inc   = fsas_pkg::CNT_W'(idx_r) + fsas_pkg::CNT_W'(1);

  assign quot = prod[fsas_pkg::PROD_W-1:fsas_pkg::DIV_SH];

  always_comb begin
    if (n_r > fsas_pkg::CNT_W'(1)) begin
      thresh = fsas_pkg::CMP_W'(sensitivity) + fsas_pkg::CMP_W'(quot);
    end else begin
      thresh = fsas_pkg::CMP_W'(sensitivity);
    end
    flame = !sun && (fsas_pkg::CMP_W'(sample_r) > thresh);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= sample;
      idx_r    <= start_idx;
      n_r      <= n_active;
    end
    if (ctrl.acc && take) begin
      sum <= sum + fsas_pkg::SUM_W'(readings[i_cnt[fsas_pkg::IDX_W-1:0]]);
    end else if (accept) begin
      sum <= '0;
    end
    if (ctrl.mul) begin
      prod <= fsas_pkg::PROD_W'(sum)
            * fsas_pkg::PROD_W'(fsas_pkg::recip(3'(n_r - fsas_pkg::CNT_W'(1))));
    end
    if (load) begin
      sensor_index  <= fsas_pkg::SENSOR_W'(idx_r);
      sun_suspected <= sun;
      flame_seen    <= flame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < fsas_pkg::MAX_SENSORS; k++) begin
        readings[k] <= '0;
      end
      cur       <= '0;
      i_cnt     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.store) begin
        readings[idx_r] <= sample_r;
      end
      if (accept) begin
        cur   <= start_idx;
        i_cnt <= '0;
      end else if (ctrl.acc) begin
        i_cnt <= i_cnt + fsas_pkg::CNT_W'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
        if (!sun) begin
          cur <= (idx_inc >= n_r) ? '0 : fsas_pkg::IDX_W'(idx_inc);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_sun_no_flame: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(sun_suspected && flame_seen))
    else $error("flame reported together with sunlight");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    accept |=> fsas_pkg::CNT_W'(idx_r) < n_r)
    else $error("selected sensor outside active set");

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    load |=> fsas_pkg::CNT_W'(cur) < n_r)
    else $error("next selection outside active set");

endmodule

// ===== sv/flame_sensor_array_scan_top.sv =====
// ----------------------------------------------------------------------------
// flame_sensor_array_scan_top: round-robin flame detector over up to five sensors
// Configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// sequence: an accepted sample word passes the store-and-accumulate step, the
//   accumulate loop that reads one stored reading per step, one multiply step
//   for the average and the result load, which waits while the last result is
//   not taken; a sunlight sample skips the averaging steps; samples do not overlap.
// reset: registers take 1 / 100 / 1023, stored readings clear to zero at once,
//   selection returns to sensor 0; a sample may be accepted right after reset
module flame_sensor_array_scan_top (
  input  logic                           clk,
  input  logic                           rst,
  fsas_sample_if.sink                    samp,
  fsas_result_if.source                  res,
  input  logic                           cfg_we,
  input  logic [fsas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsas_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [fsas_pkg::COUNT_CFG_W-1:0] sensor_count;
  logic [fsas_pkg::SAMPLE_W-1:0]    sensitivity;
  logic [fsas_pkg::SAMPLE_W-1:0]    sun_level;
  logic [fsas_pkg::CNT_W-1:0]       n_active;

  fsas_pkg::ctrl_t  ctrl;
  fsas_pkg::flags_t flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_count <= fsas_pkg::RST_SENSOR_COUNT;
      sensitivity  <= fsas_pkg::RST_SENSITIVITY;
      sun_level    <= fsas_pkg::RST_SUN_LEVEL;
    end else if (cfg_we) begin
      case (cfg_index)
        fsas_pkg::REG_SENSOR_COUNT: sensor_count <= cfg_data[fsas_pkg::COUNT_CFG_W-1:0];
        fsas_pkg::REG_SENSITIVITY:  sensitivity  <= cfg_data[fsas_pkg::SAMPLE_W-1:0];
        fsas_pkg::REG_SUN_LEVEL:    sun_level    <= cfg_data[fsas_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one sensor, large counts saturate
  always_comb begin
    if (sensor_count == '0) begin
      n_active = fsas_pkg::CNT_W'(1);
    end else if (int'(sensor_count) > fsas_pkg::MAX_SENSORS) begin
      n_active = fsas_pkg::CNT_W'(fsas_pkg::MAX_SENSORS);
    end else begin
      n_active = fsas_pkg::CNT_W'(sensor_count);
    end
  end

  assign samp.ready = ctrl.in_rdy && !rst;

  fsas_ucode u_ucode (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  fsas_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .flags         (flags),
    .sample_valid  (samp.valid),
    .sample        (samp.sample),
    .n_active      (n_active),
    .sensitivity   (sensitivity),
    .sun_level     (sun_level),
    .out_ready     (res.ready),
    .out_valid     (res.valid),
    .sensor_index  (res.sensor_index),
    .sun_suspected (res.sun_suspected),
    .flame_seen    (res.flame_seen)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the flame sensor array scanner
// Sends samples with random idling and a long result stall, predicts every
// result word with a behavioral model of the scan and compares each field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [fsas_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [fsas_pkg::SENSOR_W-1:0] sensor_index;
    logic                          sun_suspected;
    logic                          flame_seen;
  } verdict_t;

  logic                            clk;
  logic                            rst       = 1'b1;
  logic                            cfg_we    = 1'b0;
  logic [fsas_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fsas_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  fsas_sample_if samp_ch ();
  fsas_result_if res_ch ();

  flame_sensor_array_scan_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .samp      (samp_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // scanner model state
  logic [fsas_pkg::COUNT_CFG_W-1:0] m_count;
  logic [fsas_pkg::SAMPLE_W-1:0]    m_sens;
  logic [fsas_pkg::SAMPLE_W-1:0]    m_max;
  logic [fsas_pkg::SAMPLE_W-1:0]    m_readings [fsas_pkg::MAX_SENSORS];
  int unsigned                      m_sel;

  verdict_t verdict_q [$];
  int       errors    = 0;
  int       send_idle = 0;
  int       recv_idle = 0;
  int       hold_req  = 0;
  int       quiet     = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic verdict_t scan_verdict(input logic [fsas_pkg::SAMPLE_W-1:0] s);
    verdict_t    v;
    int unsigned n;
    int unsigned sum;
    n = (m_count == 0) ? 1 : (m_count > fsas_pkg::MAX_SENSORS) ? fsas_pkg::MAX_SENSORS
                                                                : m_count;
    // selection left beyond a lowered count starts over at sensor 0
    if (m_sel >= n) m_sel = 0;
    v = '0;
    v.sensor_index = fsas_pkg::SENSOR_W'(m_sel);
    m_readings[m_sel] = s;
    if (s >= m_max) begin
      v.sun_suspected = 1'b1;
    end else begin
      if (n > 1) begin
        sum = 0;
        for (int i = 0; i < n; i++) begin
          if (i != m_sel) sum += m_readings[i];
        end
        v.flame_seen = (s > m_sens + sum / (n - 1));
      end else begin
        v.flame_seen = (s > m_sens);
      end
      m_sel = (m_sel + 1 >= n) ? 0 : m_sel + 1;
    end
    return v;
  endfunction

  task automatic send_sample(input logic [fsas_pkg::SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle) begin
      samp_ch.valid <= 1'b0;
      @(posedge clk);
    end
    samp_ch.valid  <= 1'b1;
    samp_ch.sample <= s;
    @(posedge clk);
    while (!samp_ch.ready) @(posedge clk);
    verdict_q.push_back(scan_verdict(s));
  endtask

  task automatic wait_drained();
    samp_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fsas_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fsas_pkg::CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    case (idx)
      fsas_pkg::REG_SENSOR_COUNT: m_count = d[fsas_pkg::COUNT_CFG_W-1:0];
      fsas_pkg::REG_SENSITIVITY:  m_sens  = d;
      fsas_pkg::REG_SUN_LEVEL:    m_max   = d;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [fsas_pkg::CFG_DATA_W-1:0] cnt,
                            input logic [fsas_pkg::CFG_DATA_W-1:0] sens,
                            input logic [fsas_pkg::CFG_DATA_W-1:0] maxr);
    wait_drained();
    write_reg(fsas_pkg::REG_SENSOR_COUNT, cnt);
    write_reg(fsas_pkg::REG_SENSITIVITY, sens);
    write_reg(fsas_pkg::REG_SUN_LEVEL, maxr);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [fsas_pkg::SAMPLE_W-1:0] draw_sample(input int base);
    int r;
    int t;
    r = $urandom_range(99);
    if (r < 55) begin
      t = base + $urandom_range(40);
    end else if (r < 80) begin
      t = $urandom_range(1023, base);
    end else if (r < 90) begin
      t = m_max;
      t = t + $urandom_range(4);
      t = t - 2;
    end else begin
      t = $urandom_range(1023);
    end
    if (t < 0) t = 0;
    if (t > 1023) t = 1023;
    return fsas_pkg::SAMPLE_W'(t);
  endfunction

  task automatic test_reset_values();
    send_sample(10'd0);
    send_sample(10'd100);
    send_sample(10'd101);
    send_sample(10'd1023);
    send_sample(10'd1022);
  endtask

  task automatic test_directed_cases();
    set_config(10'd3, 10'd0, 10'd1023);
    send_sample(10'd1022);
    send_sample(10'd1);
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd512);
    // count above the sensor limit saturates
    set_config(10'd7, 10'd1023, 10'd1000);
    send_sample(10'd1000);
    send_sample(10'd999);
    send_sample(10'd1023);
    send_sample(10'd5);
    while (m_sel != 4) send_sample(10'd0);
    // lowering the count strands the selection past the end
    set_config(10'd2, 10'd50, 10'd700);
    send_sample(10'd699);
    send_sample(10'd10);
    // count zero acts as one sensor, sunlight level zero makes every word sunlight
    set_config(10'h3F8, 10'h3FF, 10'd0);
    send_sample(10'd0);
    send_sample(10'd1023);
    wait_drained();
    write_reg(REG_UNUSED, 10'h3FF);
    cfg_we <= 1'b0;
    send_sample(10'd512);
    send_sample(10'd512);
  endtask

  task automatic test_backpressure();
    set_config(10'd5, 10'd20, 10'd1023);
    hold_req++;
    for (int i = 0; i < 12; i++) send_sample(draw_sample(300));
  endtask

  task automatic test_random_traffic(input int items);
    int left;
    int k;
    int base;
    logic [fsas_pkg::CFG_DATA_W-1:0] cnt;
    logic [fsas_pkg::CFG_DATA_W-1:0] sens;
    logic [fsas_pkg::CFG_DATA_W-1:0] maxr;
    left = items;
    while (left > 0) begin
      if ($urandom_range(9) == 0) begin
        cnt = fsas_pkg::CFG_DATA_W'($urandom_range(7));
      end else begin
        cnt = fsas_pkg::CFG_DATA_W'($urandom_range(5, 1));
      end
      case ($urandom_range(9))
        0:       sens = 10'd0;
        1:       sens = 10'd1023;
        default: sens = fsas_pkg::CFG_DATA_W'($urandom_range(200));
      endcase
      case ($urandom_range(9))
        0:          maxr = 10'd0;
        1:          maxr = fsas_pkg::CFG_DATA_W'($urandom_range(1023));
        2, 3, 4:    maxr = 10'd1023;
        default:    maxr = fsas_pkg::CFG_DATA_W'($urandom_range(1022, 700));
      endcase
      set_config(cnt, sens, maxr);
      k = $urandom_range(60, 8);
      if (k > left) k = left;
      base = $urandom_range(600);
      for (int i = 0; i < k; i++) send_sample(draw_sample(base));
      left -= k;
    end
  endtask

  // result side: random stall, or a long hold when one is requested
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (verdict_q.size() == 0) begin
        errors++;
        $error("result word with none expected: sensor_index %0d", res_ch.sensor_index);
      end else begin
        want = verdict_q.pop_front();
        if (res_ch.sensor_index !== want.sensor_index) begin
          errors++;
          $error("sensor_index: expected %0d, got %0d", want.sensor_index,
                 res_ch.sensor_index);
        end
        if (res_ch.sun_suspected !== want.sun_suspected) begin
          errors++;
          $error("sun_suspected: expected %0b, got %0b", want.sun_suspected,
                 res_ch.sun_suspected);
        end
        if (res_ch.flame_seen !== want.flame_seen) begin
          errors++;
          $error("flame_seen: expected %0b, got %0b", want.flame_seen,
                 res_ch.flame_seen);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (samp_ch.valid && samp_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    samp_ch.valid  = 1'b0;
    samp_ch.sample = '0;
    m_count = fsas_pkg::RST_SENSOR_COUNT;
    m_sens  = fsas_pkg::RST_SENSITIVITY;
    m_max   = fsas_pkg::RST_SUN_LEVEL;
    m_sel   = 0;
    for (int i = 0; i < fsas_pkg::MAX_SENSORS; i++) m_readings[i] = '0;
    send_idle = 27;
    recv_idle = 48;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed_cases();
    test_backpressure();
    test_random_traffic(410);
    send_idle = 48;
    recv_idle = 27;
    test_random_traffic(410);
    send_idle = 0;
    recv_idle = 0;
    test_random_traffic(410);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
